// ===== rtl/plob_pkg.sv =====
package plob_pkg;

    localparam int LEVELS_DEF = 64;

    localparam logic [1:0] KIND_DELTA    = 2'd0;
    localparam logic [1:0] KIND_SNAPSHOT = 2'd1;
    localparam logic [1:0] KIND_CLEAR    = 2'd2;

    typedef struct packed {
        logic [31:0] price;
        logic [30:0] qty;
    } entry_t;

    typedef struct packed {
        logic take;
        logic scan_clr;
        logic scan_step;
        logic rd_pos;
        logic found_load;
        logic idx_load_del;
        logic idx_load_ins;
        logic move_wr;
        logic wr_new;
        logic wr_append;
        logic cnt_clr;
        logic cnt_ins;
        logic cnt_dec;
        logic status_set;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic [1:0] kind;
        logic       positive;
        logic       full;
        logic       pos_lt_n;
        logic       ahead;
        logic       found;
        logic       idx_gt_pos;
        logic       idx1_lt_n;
        logic       out_busy;
    } stat_t;

endpackage

// ===== rtl/plob_ctrl.sv =====
module plob_ctrl import plob_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_tvalid,
    output logic  s_tready,
    input  stat_t stat,
    output cmd_t  cmd
);

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_EXEC     = 4'd1;
    localparam logic [3:0] ST_SCAN_RD  = 4'd2;
    localparam logic [3:0] ST_SCAN_CMP = 4'd3;
    localparam logic [3:0] ST_DECIDE   = 4'd4;
    localparam logic [3:0] ST_INS_RD   = 4'd5;
    localparam logic [3:0] ST_INS_WR   = 4'd6;
    localparam logic [3:0] ST_DEL_RD   = 4'd7;
    localparam logic [3:0] ST_DEL_WR   = 4'd8;
    localparam logic [3:0] ST_FINISH   = 4'd9;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid && s_tready) begin
                    cmd.take   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                state_next = ST_FINISH;
                if (stat.kind == KIND_CLEAR) begin
                    cmd.cnt_clr = 1'b1;
                end else if (stat.kind == KIND_SNAPSHOT) begin
                    if (stat.positive) begin
                        if (stat.full) begin
                            cmd.status_set = 1'b1;
                        end else begin
                            cmd.wr_append = 1'b1;
                            cmd.cnt_ins   = 1'b1;
                        end
                    end
                end else if (stat.kind == KIND_DELTA) begin
                    cmd.scan_clr = 1'b1;
                    state_next   = ST_SCAN_RD;
                end
            end
            ST_SCAN_RD: begin
                if (stat.pos_lt_n) begin
                    cmd.rd_pos = 1'b1;
                    state_next = ST_SCAN_CMP;
                end else begin
                    cmd.found_load = 1'b1;
                    state_next     = ST_DECIDE;
                end
            end
            ST_SCAN_CMP: begin
                if (stat.ahead) begin
                    cmd.scan_step = 1'b1;
                    state_next    = ST_SCAN_RD;
                end else begin
                    cmd.found_load = 1'b1;
                    state_next     = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                state_next = ST_FINISH;
                if (!stat.positive) begin
                    if (stat.found) begin
                        cmd.idx_load_del = 1'b1;
                        state_next       = ST_DEL_RD;
                    end
                end else if (stat.found) begin
                    cmd.wr_new = 1'b1;
                end else if (stat.full) begin
                    cmd.status_set = 1'b1;
                    if (stat.pos_lt_n) begin
                        cmd.idx_load_ins = 1'b1;
                        state_next       = ST_INS_RD;
                    end
                end else begin
                    cmd.idx_load_ins = 1'b1;
                    state_next       = ST_INS_RD;
                end
            end
            ST_INS_RD: begin
                if (stat.idx_gt_pos) begin
                    state_next = ST_INS_WR;
                end else begin
                    cmd.wr_new  = 1'b1;
                    cmd.cnt_ins = 1'b1;
                    state_next  = ST_FINISH;
                end
            end
            ST_INS_WR: begin
                cmd.move_wr = 1'b1;
                state_next  = ST_INS_RD;
            end
            ST_DEL_RD: begin
                if (stat.idx1_lt_n) begin
                    state_next = ST_DEL_WR;
                end else begin
                    cmd.cnt_dec = 1'b1;
                    state_next  = ST_FINISH;
                end
            end
            ST_DEL_WR: begin
                cmd.move_wr = 1'b1;
                state_next  = ST_DEL_RD;
            end
            ST_FINISH: begin
                if (!stat.out_busy) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/plob_datapath.sv =====
module plob_datapath import plob_pkg::*; #(
    parameter int LEVELS_PER_SIDE = LEVELS_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic [63:0]   s_tdata,
    input  logic [2:0]    s_tuser,
    input  logic          m_tready,
    output logic          m_tvalid,
    output logic [127:0]  m_tdata,
    output logic          m_tuser,
    input  cmd_t          cmd,
    output stat_t         stat
);

    localparam int CNT_W  = $clog2(LEVELS_PER_SIDE + 1);
    localparam int IDX_W  = $clog2(LEVELS_PER_SIDE);
    localparam int ADDR_W = IDX_W + 1;
    localparam int DEPTH  = 2 ** ADDR_W;
    localparam logic [CNT_W-1:0] FULL = CNT_W'(LEVELS_PER_SIDE);
    localparam logic [CNT_W-1:0] ONE  = CNT_W'(1);

    logic [1:0]        kind_reg;
    logic              ask_reg;
    logic [31:0]       price_reg;
    logic [30:0]       qty_reg;
    logic              positive_reg;
    logic [CNT_W-1:0]  pos_reg;
    logic [CNT_W-1:0]  idx_reg;
    logic              del_reg;
    logic              found_reg;
    logic              status_reg;
    logic [CNT_W-1:0]  cnt_reg [2];
    entry_t            head_reg [2];
    entry_t            rdata_reg;
    entry_t            mem [DEPTH];
    logic              m_tvalid_reg;
    logic [127:0]      m_tdata_reg;
    logic              m_tuser_reg;

    logic [CNT_W-1:0]  n;
    logic [CNT_W-1:0]  idx_plus;
    logic [CNT_W-1:0]  idx_minus;
    logic [IDX_W-1:0]  waddr;
    logic [IDX_W-1:0]  raddr;
    logic              we;
    entry_t            wdata;
    logic              match;
    logic [31:0]       bid_price;
    logic [30:0]       bid_qty;
    logic [31:0]       ask_price;
    logic [30:0]       ask_qty;

    assign n         = cnt_reg[ask_reg];
    assign idx_plus  = idx_reg + ONE;
    assign idx_minus = idx_reg - ONE;
    assign match     = (rdata_reg.price == price_reg);

    assign we    = cmd.move_wr || cmd.wr_new || cmd.wr_append;
    assign wdata = cmd.move_wr ? rdata_reg : entry_t'{price: price_reg, qty: qty_reg};

    always_comb begin
        priority if (cmd.move_wr) begin
            waddr = idx_reg[IDX_W-1:0];
        end else if (cmd.wr_new) begin
            waddr = pos_reg[IDX_W-1:0];
        end else begin
            waddr = n[IDX_W-1:0];
        end
    end

    always_comb begin
        priority if (cmd.rd_pos) begin
            raddr = pos_reg[IDX_W-1:0];
        end else if (del_reg) begin
            raddr = idx_plus[IDX_W-1:0];
        end else begin
            raddr = idx_minus[IDX_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[{ask_reg, waddr}] <= wdata;
        end
        rdata_reg <= mem[{ask_reg, raddr}];
    end

    always_ff @(posedge aclk) begin
        if (we && (waddr == '0)) begin
            head_reg[ask_reg] <= wdata;
        end
    end

    always_comb begin
        stat.kind       = kind_reg;
        stat.positive   = positive_reg;
        stat.full       = (n == FULL);
        stat.pos_lt_n   = (pos_reg < n);
        stat.ahead      = ask_reg ? (rdata_reg.price < price_reg)
                                  : (rdata_reg.price > price_reg);
        stat.found      = found_reg;
        stat.idx_gt_pos = (idx_reg > pos_reg);
        stat.idx1_lt_n  = (idx_plus < n);
        stat.out_busy   = m_tvalid_reg && !m_tready;
    end

    // item, status, scan, found and index registers
    always_ff @(posedge aclk) begin
        if (cmd.take) begin
            kind_reg     <= s_tuser[1:0];
            ask_reg      <= s_tuser[2];
            price_reg    <= s_tdata[31:0];
            qty_reg      <= s_tdata[62:32];
            positive_reg <= !s_tdata[63] && (s_tdata[62:32] != '0);
        end
        if (cmd.take) begin
            status_reg <= 1'b0;
        end else if (cmd.status_set) begin
            status_reg <= 1'b1;
        end
        if (cmd.scan_clr) begin
            pos_reg <= '0;
        end else if (cmd.scan_step) begin
            pos_reg <= pos_reg + ONE;
        end
        if (cmd.found_load) begin
            found_reg <= stat.pos_lt_n && match;
        end
        if (cmd.idx_load_del) begin
            idx_reg <= pos_reg;
            del_reg <= 1'b1;
        end else if (cmd.idx_load_ins) begin
            idx_reg <= (n == FULL) ? (n - ONE) : n;
            del_reg <= 1'b0;
        end else if (cmd.move_wr) begin
            idx_reg <= del_reg ? idx_plus : idx_minus;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg[0] <= '0;
            cnt_reg[1] <= '0;
        end else if (cmd.cnt_clr) begin
            cnt_reg[0] <= '0;
            cnt_reg[1] <= '0;
        end else if (cmd.cnt_ins) begin
            if (n != FULL) begin
                cnt_reg[ask_reg] <= n + ONE;
            end
        end else if (cmd.cnt_dec) begin
            cnt_reg[ask_reg] <= n - ONE;
        end
    end

    assign bid_price = (cnt_reg[0] != '0) ? head_reg[0].price : 32'd0;
    assign bid_qty   = (cnt_reg[0] != '0) ? head_reg[0].qty   : 31'd0;
    assign ask_price = (cnt_reg[1] != '0) ? head_reg[1].price : 32'd0;
    assign ask_qty   = (cnt_reg[1] != '0) ? head_reg[1].qty   : 31'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_tdata_reg <= {ask_qty, ask_price, (cnt_reg[1] != '0),
                            bid_qty, bid_price, (cnt_reg[0] != '0)};
            m_tuser_reg <= status_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// ===== rtl/price_level_order_book.sv =====
// channel   | dir | words
// s_ (in)   | in  | tdata: level_price, level_qty; tuser: kind, is_ask
// m_ (out)  | out | tdata: best bid valid/price/qty, best ask valid/price/qty; tuser: status
//
// one word in flight at a time; one result word per input word
// clear, snapshot and unused kinds pass through EXEC and FINISH only; FINISH loads the result
// delta: a SCAN_RD and a SCAN_CMP step per level scanned plus a read and a write step per level
// moved, through the one read port and one write port of the level memory
// synchronous active-low reset empties both sides; the level memory is not cleared
// input stalls while a word is at work; a finished word waits while a result is held
module price_level_order_book import plob_pkg::*; #(
    parameter int LEVELS_PER_SIDE = LEVELS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [63:0]  s_tdata,  // level_price, level_qty
    input  logic [2:0]   s_tuser,  // kind, is_ask
    output logic         m_tvalid,
    input  logic         m_tready,
    // best_bid_valid, best_bid_price, best_bid_qty, best_ask_valid, best_ask_price,
    // best_ask_qty
    output logic [127:0] m_tdata,
    output logic         m_tuser   // status
);

    cmd_t  cmd;
    stat_t stat;

    plob_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    plob_datapath #(
        .LEVELS_PER_SIDE (LEVELS_PER_SIDE)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cmd      (cmd),
        .stat     (stat)
    );

endmodule

// ===== sim/price_level_order_book_tb.sv =====
module price_level_order_book_tb;
    import plob_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = LEVELS_DEF;
    localparam int LIMIT_CYCLES = 2_000_000;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int TAIL_CYCLES = 4 * DEPTH + 40;
    localparam int RANDOM_WORDS = 1200;
    localparam logic [1:0] KIND_NONE = 2'd3;

    typedef struct packed {
        logic        bid_v;
        logic [31:0] bid_p;
        logic [30:0] bid_q;
        logic        ask_v;
        logic [31:0] ask_p;
        logic [30:0] ask_q;
        logic        status;
    } book_top_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic        is_ask;
        logic [31:0] price;
        logic [31:0] qty;
        logic        want_empty;
    } row_t;

    // hand-written rows; want_empty marks rows whose result is an empty book
    localparam int NUM_ROWS = 22;
    localparam row_t DIRECTED [NUM_ROWS] = '{
        '{KIND_DELTA,    1'b0, 32'd100,        32'd0,          1'b1},
        '{KIND_NONE,     1'b0, 32'hffff_ffff,  32'h7fff_ffff,  1'b1},
        '{KIND_SNAPSHOT, 1'b1, 32'd5,          32'h8000_0000,  1'b1},
        '{KIND_SNAPSHOT, 1'b0, 32'd7,          32'd0,          1'b1},
        '{KIND_DELTA,    1'b1, 32'd9,          32'hffff_ffff,  1'b1},
        '{KIND_DELTA,    1'b0, 32'd100,        32'd50,         1'b0},
        '{KIND_DELTA,    1'b0, 32'hffff_ffff,  32'h7fff_ffff,  1'b0},
        '{KIND_DELTA,    1'b0, 32'd0,          32'd1,          1'b0},
        '{KIND_DELTA,    1'b1, 32'd0,          32'd1,          1'b0},
        '{KIND_DELTA,    1'b1, 32'hffff_ffff,  32'h7fff_ffff,  1'b0},
        '{KIND_DELTA,    1'b1, 32'd500,        32'd20,         1'b0},
        '{KIND_DELTA,    1'b0, 32'd100,        32'd60,         1'b0},
        '{KIND_DELTA,    1'b0, 32'hffff_ffff,  32'h8000_0000,  1'b0},
        '{KIND_DELTA,    1'b1, 32'd0,          32'd0,          1'b0},
        '{KIND_SNAPSHOT, 1'b0, 32'd5000,       32'd3,          1'b0},
        '{KIND_DELTA,    1'b0, 32'd4000,       32'd9,          1'b0},
        '{KIND_SNAPSHOT, 1'b1, 32'd1,          32'd12,         1'b0},
        '{KIND_DELTA,    1'b0, 32'd200,        32'hffff_ffff,  1'b0},
        '{KIND_NONE,     1'b1, 32'd0,          32'd5,          1'b0},
        '{KIND_CLEAR,    1'b1, 32'hffff_ffff,  32'h7fff_ffff,  1'b1},
        '{KIND_DELTA,    1'b1, 32'd40,         32'd2,          1'b0},
        '{KIND_CLEAR,    1'b0, 32'd0,          32'd0,          1'b1}
    };

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [63:0]  s_tdata = '0;   // level_price, level_qty
    logic [2:0]   s_tuser = '0;   // kind, is_ask
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [127:0] m_tdata;        // bid valid, price, qty, ask valid, price, qty
    logic         m_tuser;        // status

    // book state as the block should hold it, index 0 bids, 1 asks
    logic [31:0] level_px [2][DEPTH];
    logic [30:0] level_qt [2][DEPTH];
    int          level_cnt [2];

    book_top_t book_tops_due [$];
    int  fail_cnt = 0;
    int  words_in = 0;
    int  words_out = 0;
    int  full_cnt = 0;
    int  deepest = 0;
    int  cycle_cnt = 0;
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    bit  hold_req = 1'b0;

    price_level_order_book i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #5 aclk = ~aclk;

    task automatic book_apply(input logic [1:0] kind, input logic side,
                              input logic [31:0] price, input logic [31:0] qty,
                              output book_top_t top);
        int  n;
        int  pos;
        int  last;
        int  i;
        bit  found;
        bit  positive;
        bit  st;
        positive = !qty[31] && (qty != 32'd0);
        st = 1'b0;
        n = level_cnt[side];
        if (kind == KIND_DELTA) begin
            pos = 0;
            while (pos < n && (side ? level_px[side][pos] < price
                                    : level_px[side][pos] > price))
                pos++;
            found = (pos < n) && (level_px[side][pos] == price);
            if (!positive) begin
                if (found) begin
                    for (i = pos; i + 1 < n; i++) begin
                        level_px[side][i] = level_px[side][i + 1];
                        level_qt[side][i] = level_qt[side][i + 1];
                    end
                    level_cnt[side] = n - 1;
                end
            end else if (found) begin
                level_qt[side][pos] = qty[30:0];
            end else begin
                // on a full side the deepest level falls off, or the new one
                last = (n < DEPTH) ? n : DEPTH - 1;
                for (i = last; i > pos; i--) begin
                    level_px[side][i] = level_px[side][i - 1];
                    level_qt[side][i] = level_qt[side][i - 1];
                end
                if (pos <= last) begin
                    level_px[side][pos] = price;
                    level_qt[side][pos] = qty[30:0];
                end
                if (n < DEPTH)
                    level_cnt[side] = n + 1;
                else
                    st = 1'b1;
            end
        end else if (kind == KIND_SNAPSHOT) begin
            if (positive) begin
                if (n >= DEPTH) begin
                    st = 1'b1;
                end else begin
                    level_px[side][n] = price;
                    level_qt[side][n] = qty[30:0];
                    level_cnt[side] = n + 1;
                end
            end
        end else if (kind == KIND_CLEAR) begin
            level_cnt[0] = 0;
            level_cnt[1] = 0;
        end
        top = '0;
        if (level_cnt[0] > 0) begin
            top.bid_v = 1'b1;
            top.bid_p = level_px[0][0];
            top.bid_q = level_qt[0][0];
        end
        if (level_cnt[1] > 0) begin
            top.ask_v = 1'b1;
            top.ask_p = level_px[1][0];
            top.ask_q = level_qt[1][0];
        end
        top.status = st;
        if (st)
            full_cnt++;
        if (level_cnt[side] > deepest)
            deepest = level_cnt[side];
    endtask

    task automatic offer_word(input logic [1:0] kind, input logic is_ask,
                              input logic [31:0] price, input logic [31:0] qty,
                              input bit want_empty);
        book_top_t top;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {qty, price};
        s_tuser  <= {is_ask, kind};
        do @(posedge aclk); while (!s_tready);
        book_apply(kind, is_ask, price, qty, top);
        if (want_empty)
            top = '0;
        book_tops_due.insert(book_tops_due.size(), top);
        words_in++;
    endtask

    task automatic drain_book_tops();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (book_tops_due.size() != 0);
    endtask

    function automatic logic [31:0] pick_qty(input int pos_pct);
        logic [31:0] v;
        if ($urandom_range(0, 99) < pos_pct) begin
            case ($urandom_range(0, 5))
                0: v = 32'd1;
                1: v = 32'h7fff_ffff;
                2: v = $urandom_range(1, 1000);
                default: begin
                    v = $urandom & 32'h7fff_ffff;
                    if (v == 32'd0)
                        v = 32'd1;
                end
            endcase
        end else begin
            case ($urandom_range(0, 3))
                0: v = 32'd0;
                1: v = 32'h8000_0000;
                2: v = 32'hffff_ffff;
                default: v = $urandom | 32'h8000_0000;
            endcase
        end
        return v;
    endfunction

    // one burst of related words, most of them around a random price base
    task automatic run_burst();
        logic [31:0] base;
        logic        side;
        int          i;
        base = $urandom;
        side = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
                for (i = 0; i < 40; i++)
                    offer_word(KIND_DELTA, 1'($urandom_range(0, 1)),
                               base + $urandom_range(0, 60), pick_qty(75), 1'b0);
            end
            4, 5: begin
                // fill one side past its depth
                for (i = 0; i < 100; i++)
                    offer_word(KIND_DELTA, side, base + $urandom_range(0, 300),
                               pick_qty(92), 1'b0);
            end
            6: begin
                for (i = 0; i < 70; i++)
                    offer_word(($urandom_range(0, 9) == 0) ? KIND_DELTA : KIND_SNAPSHOT,
                               side, base + $urandom_range(0, 200), pick_qty(85), 1'b0);
            end
            7: begin
                for (i = 0; i < 10; i++)
                    offer_word(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                               $urandom, $urandom, 1'b0);
            end
            8: begin
                offer_word(KIND_CLEAR, 1'($urandom_range(0, 1)), $urandom, $urandom, 1'b0);
            end
            default: begin
                for (i = 0; i < 30; i++)
                    offer_word(KIND_DELTA, side, base + $urandom_range(0, 40),
                               pick_qty(20), 1'b0);
            end
        endcase
    endtask

    // receiver with random back-pressure and one long hold-off, asked for in the receiver phase
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                hold_left = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge aclk) begin : check_result
        book_top_t want;
        book_top_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.bid_v  = m_tdata[0];
            got.bid_p  = m_tdata[32:1];
            got.bid_q  = m_tdata[63:33];
            got.ask_v  = m_tdata[64];
            got.ask_p  = m_tdata[96:65];
            got.ask_q  = m_tdata[127:97];
            got.status = m_tuser;
            words_out++;
            if (book_tops_due.size() == 0) begin
                $error("result word with nothing expected");
                fail_cnt++;
            end else begin
                want = book_tops_due.pop_front();
                if (got != want)
                    fail_cnt++;
                if (got.bid_v != want.bid_v)
                    $error("best_bid_valid: expected %0d, got %0d", want.bid_v, got.bid_v);
                if (got.bid_p != want.bid_p)
                    $error("best_bid_price: expected %0h, got %0h", want.bid_p, got.bid_p);
                if (got.bid_q != want.bid_q)
                    $error("best_bid_qty: expected %0h, got %0h", want.bid_q, got.bid_q);
                if (got.ask_v != want.ask_v)
                    $error("best_ask_valid: expected %0d, got %0d", want.ask_v, got.ask_v);
                if (got.ask_p != want.ask_p)
                    $error("best_ask_price: expected %0h, got %0h", want.ask_p, got.ask_p);
                if (got.ask_q != want.ask_q)
                    $error("best_ask_qty: expected %0h, got %0h", want.ask_q, got.ask_q);
                if (got.status != want.status)
                    $error("status: expected %0d, got %0d", want.status, got.status);
            end
        end
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        int r;
        int ph;
        level_cnt[0] = 0;
        level_cnt[1] = 0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        for (r = 0; r < NUM_ROWS; r++)
            offer_word(DIRECTED[r].kind, DIRECTED[r].is_ask, DIRECTED[r].price,
                       DIRECTED[r].qty, DIRECTED[r].want_empty);
        drain_book_tops();

        // idle phases: none, sender, receiver, both, none
        for (ph = 0; ph < 5; ph++) begin
            case (ph)
                1: begin send_idle_pct = 74; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 74; end
                3: begin send_idle_pct = 32; recv_stall_pct = 32; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            if (ph == 2)
                hold_req = 1'b1;
            while (words_in < NUM_ROWS + RANDOM_WORDS * (ph + 1) / 5)
                run_burst();
            drain_book_tops();
        end

        repeat (TAIL_CYCLES) @(posedge aclk);
        $display("%0d words sent, %0d results checked, %0d of them on a full side",
                 words_in, words_out, full_cnt);
        $display("deepest side reached %0d levels of %0d", deepest, DEPTH);
        if (fail_cnt == 0 && book_tops_due.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("%0d mismatches, %0d results missing", fail_cnt, book_tops_due.size());
            $display("simulation failed");
        end
        $finish;
    end

endmodule
